/* src/tbhr_pkg.sv */
// Shared types, codes and constants for the two-button hold/reset controller.
// No dependencies; the interfaces, channel and top level refer to it by scope, and the bench imports it.
package tbhr_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMD_WIDTH   = 2;
    localparam int NUM_BUTTONS = 2;

    localparam logic [CFG_WIDTH-1:0] HOLD_TIME_RESET     = 16'd3000;
    localparam logic [CFG_WIDTH-1:0] CANCEL_WINDOW_RESET = 16'd3000;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_ARMED   = 2'd2
    } mode_t;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK    = 2'd0,
        CMD_PRESS   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_HOLD_TIME     = 1'b0,
        REG_CANCEL_WINDOW = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic step;
        logic tick;
        logic press_evt;
        logic release_evt;
    } chan_event_t;

    typedef struct packed {
        logic short_press;
        logic fire;
        logic cancelled;
        logic armed;
    } chan_result_t;

    function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CFG_WIDTH-1:0] v);
        logic [COUNT_WIDTH+CFG_WIDTH-1:0] ext;
        ext = {{COUNT_WIDTH{1'b0}}, v};
        return ext[COUNT_WIDTH-1:0];
    endfunction

endpackage

/* src/tbhr_if.sv */
// Valid/ready channel interfaces: request, result and register write.
// Depends on tbhr_pkg for field widths.
interface tbhr_req_if;
    logic                           valid;
    logic                           ready;
    logic [tbhr_pkg::CMD_WIDTH-1:0] cmd;
    logic                           button;

    modport source (output valid, output cmd, output button, input ready);
    modport sink   (input valid, input cmd, input button, output ready);
endinterface

interface tbhr_rsp_if;
    logic       valid;
    logic       ready;
    logic       confirm_pulse;
    logic       reject_pulse;
    logic       factory_reset_fire;
    logic       commission_reset_fire;
    logic [1:0] cancelled_flags;
    logic [1:0] armed_flags;

    modport source (output valid, output confirm_pulse, output reject_pulse,
                    output factory_reset_fire, output commission_reset_fire,
                    output cancelled_flags, output armed_flags, input ready);
    modport sink   (input valid, input confirm_pulse, input reject_pulse,
                    input factory_reset_fire, input commission_reset_fire,
                    input cancelled_flags, input armed_flags, output ready);
endinterface

interface tbhr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic                           index;
    logic [tbhr_pkg::CFG_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/tbhr_channel.sv */
// One button channel: mode state machine and hold/cancel down counter.
// Depends on tbhr_pkg for mode codes, event/result structs and load_count.
module tbhr_channel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tbhr_pkg::chan_event_t               ev,
    input  logic [tbhr_pkg::CFG_WIDTH-1:0]      hold_time,
    input  logic [tbhr_pkg::CFG_WIDTH-1:0]      cancel_window,
    output tbhr_pkg::chan_result_t              res
);

    tbhr_pkg::mode_t                     mode_reg;
    tbhr_pkg::mode_t                     mode_next;
    logic [tbhr_pkg::COUNT_WIDTH-1:0]    count_reg;
    logic [tbhr_pkg::COUNT_WIDTH-1:0]    count_next;
    logic                                expired;

    assign expired = (count_reg <= tbhr_pkg::COUNT_WIDTH'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tbhr_pkg::MODE_IDLE;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (ev.step)
        begin
            unique case (mode_reg)
                tbhr_pkg::MODE_PENDING:
                begin
                    if (ev.tick)
                    begin
                        if (expired)
                        begin
                            mode_next  = tbhr_pkg::MODE_ARMED;
                            count_next = tbhr_pkg::load_count(cancel_window);
                        end
                        else
                        begin
                            count_next = count_reg - tbhr_pkg::COUNT_WIDTH'(1);
                        end
                    end
                    else if (ev.release_evt)
                    begin
                        mode_next  = tbhr_pkg::MODE_IDLE;
                        count_next = '0;
                    end
                end
                tbhr_pkg::MODE_ARMED:
                begin
                    if (ev.tick)
                    begin
                        if (expired)
                        begin
                            mode_next  = tbhr_pkg::MODE_IDLE;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg - tbhr_pkg::COUNT_WIDTH'(1);
                        end
                    end
                    else if (ev.release_evt)
                    begin
                        mode_next  = tbhr_pkg::MODE_IDLE;
                        count_next = '0;
                    end
                end
                default:
                begin
                    if (ev.press_evt)
                    begin
                        mode_next  = tbhr_pkg::MODE_PENDING;
                        count_next = tbhr_pkg::load_count(hold_time);
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res.short_press = (mode_reg == tbhr_pkg::MODE_PENDING) && ev.release_evt;
        res.fire        = (mode_reg == tbhr_pkg::MODE_ARMED) && ev.tick && expired;
        res.cancelled   = (mode_reg == tbhr_pkg::MODE_ARMED) && ev.release_evt;
        res.armed       = (mode_next == tbhr_pkg::MODE_ARMED);
    end

endmodule

/* src/two_button_hold_reset_controller_top.sv */
// Top level of the two-button hold/reset controller: request and result
// registers, register file and two button channels. Depends on tbhr_pkg,
// tbhr_if and tbhr_channel.
//
// Usage:
//   req  - one request per item: cmd (tick, press, release) and button.
//   rsp  - exactly one result per request: short-press pulses, reset fires,
//          cancelled flags and the armed flags after the request.
//   cfg  - register writes, index 0 hold_time, index 1 cancel_window; always
//          ready. Write only while no request is in flight.
// The request register loads at the accept edge, and the channel update then
// loads the result register, so each result passes through both registers
// before it can be accepted. Throughput is one request per cycle while the
// result is not stalled; both channels update in the single combinational
// pass between the two registers.
// Reset puts both channels idle with zero counters, loads 3000 into both
// registers and empties both pipeline registers.
// A stalled result holds the result register; the request register then
// holds too, and req.ready drops once both are full.
module two_button_hold_reset_controller_top (
    input  logic  clk,
    input  logic  rst_n,
    tbhr_req_if.sink   req,
    tbhr_rsp_if.source rsp,
    tbhr_cfg_if.sink   cfg
);

    logic                               req_valid_reg;
    logic [tbhr_pkg::CMD_WIDTH-1:0]     cmd_reg;
    logic                               button_reg;
    logic [tbhr_pkg::CFG_WIDTH-1:0]     hold_time_reg;
    logic [tbhr_pkg::CFG_WIDTH-1:0]     cancel_window_reg;
    logic                               rsp_valid_reg;
    logic                               confirm_reg;
    logic                               reject_reg;
    logic                               factory_reg;
    logic                               commission_reg;
    logic [1:0]                         cancelled_reg;
    logic [1:0]                         armed_reg;
    logic                               advance;
    tbhr_pkg::chan_event_t              ev [tbhr_pkg::NUM_BUTTONS];
    tbhr_pkg::chan_result_t             res [tbhr_pkg::NUM_BUTTONS];

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg     <= tbhr_pkg::HOLD_TIME_RESET;
            cancel_window_reg <= tbhr_pkg::CANCEL_WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tbhr_pkg::REG_HOLD_TIME:     hold_time_reg     <= cfg.data;
                tbhr_pkg::REG_CANCEL_WINDOW: cancel_window_reg <= cfg.data;
                default:                     hold_time_reg     <= hold_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg    <= req.cmd;
            button_reg <= req.button;
        end
    end

    for (genvar i = 0; i < tbhr_pkg::NUM_BUTTONS; i++)
    begin : g_chan
        always_comb
        begin
            ev[i].step        = advance;
            ev[i].tick        = advance && (cmd_reg == tbhr_pkg::CMD_TICK);
            ev[i].press_evt   = advance && (cmd_reg == tbhr_pkg::CMD_PRESS)
                                && (button_reg == 1'(i));
            ev[i].release_evt = advance && (cmd_reg == tbhr_pkg::CMD_RELEASE)
                                && (button_reg == 1'(i));
        end

        tbhr_channel u_chan (
            .clk           (clk),
            .rst_n         (rst_n),
            .ev            (ev[i]),
            .hold_time     (hold_time_reg),
            .cancel_window (cancel_window_reg),
            .res           (res[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            confirm_reg    <= res[0].short_press;
            reject_reg     <= res[1].short_press;
            factory_reg    <= res[0].fire;
            commission_reg <= res[1].fire;
            cancelled_reg  <= {res[1].cancelled, res[0].cancelled};
            armed_reg      <= {res[1].armed, res[0].armed};
        end
    end

    assign rsp.valid                 = rsp_valid_reg;
    assign rsp.confirm_pulse         = confirm_reg;
    assign rsp.reject_pulse          = reject_reg;
    assign rsp.factory_reset_fire    = factory_reg;
    assign rsp.commission_reset_fire = commission_reg;
    assign rsp.cancelled_flags       = cancelled_reg;
    assign rsp.armed_flags           = armed_reg;

endmodule

/* src/tbhr_checker.sv */
// Port-level assertions for the two-button hold/reset controller, bound to
// the top level. Depends on the top level's interface ports only.
module tbhr_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic       confirm_pulse,
    input  logic       reject_pulse,
    input  logic       factory_reset_fire,
    input  logic       commission_reset_fire,
    input  logic [1:0] cancelled_flags,
    input  logic [1:0] armed_flags
);

    logic [7:0] rsp_bits;

    assign rsp_bits = {confirm_pulse, reject_pulse, factory_reset_fire,
                       commission_reset_fire, cancelled_flags, armed_flags};

    a_short_vs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !((confirm_pulse || reject_pulse || (cancelled_flags != 2'b00))
                        && (factory_reset_fire || commission_reset_fire)))
        else $error("short press or cancel reported together with a reset fire");

    a_one_release: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($countones({confirm_pulse, reject_pulse, cancelled_flags}) <= 1))
        else $error("more than one release outcome in one result");

    a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (((cancelled_flags & armed_flags) == 2'b00)
                       && !(factory_reset_fire && armed_flags[0])
                       && !(commission_reset_fire && armed_flags[1])))
        else $error("button still armed after cancel or reset fire");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
        else $error("stalled result dropped or changed");

endmodule

bind two_button_hold_reset_controller_top tbhr_checker u_tbhr_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .confirm_pulse         (rsp.confirm_pulse),
    .reject_pulse          (rsp.reject_pulse),
    .factory_reset_fire    (rsp.factory_reset_fire),
    .commission_reset_fire (rsp.commission_reset_fire),
    .cancelled_flags       (rsp.cancelled_flags),
    .armed_flags           (rsp.armed_flags)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for two_button_hold_reset_controller_top: a directed table, then
// random press/tick/release sequences under several hold/cancel settings, checked per result.
// Depends on tbhr_pkg, the tbhr interfaces and the controller RTL.
module tb;
    import tbhr_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic       confirm;
        logic       reject;
        logic       factory;
        logic       commission;
        logic [1:0] cancelled;
        logic [1:0] armed;
    } outcome_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_style_t;

    typedef struct {
        row_kind_t              kind;
        logic [CMD_WIDTH-1:0]   cmd;
        logic                   btn;
        logic                   known;
        outcome_t               want;
        logic [CFG_WIDTH-1:0]   hold;
        logic [CFG_WIDTH-1:0]   cancel;
    } row_t;

    // want bits: confirm, reject, factory, commission, cancelled[1:0], armed[1:0]
    row_t plan [31] = '{
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b1, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_UNUSED,  1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b1, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b0, 1'b1, 8'b1000_0000, '0, '0},
        '{ROW_CFG, CMD_TICK,    1'b0, 1'b0, 8'b0000_0000, 16'd0, 16'd1},
        '{ROW_REQ, CMD_PRESS,   1'b1, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0000_0010, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b1, 1'b1, 8'b0000_0010, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b1, 1'b1, 8'b0000_1000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b1, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0000_0011, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b1, 1'b1, 8'b0011_0000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b1, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b1, 1'b1, 8'b0100_0000, '0, '0},
        '{ROW_REQ, CMD_PRESS,   1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0000_0001, '0, '0},
        '{ROW_REQ, CMD_UNUSED,  1'b1, 1'b1, 8'b0000_0001, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0010_0000, '0, '0},
        '{ROW_CFG, CMD_TICK,    1'b0, 1'b0, 8'b0000_0000, 16'd65535, 16'd0},
        '{ROW_REQ, CMD_PRESS,   1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b1, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b0, 1'b1, 8'b1000_0000, '0, '0},
        '{ROW_CFG, CMD_TICK,    1'b0, 1'b0, 8'b0000_0000, 16'd2, 16'd65535},
        '{ROW_REQ, CMD_PRESS,   1'b1, 1'b0, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b0, 1'b0, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_TICK,    1'b1, 1'b0, 8'b0000_0000, '0, '0},
        '{ROW_REQ, CMD_RELEASE, 1'b1, 1'b0, 8'b0000_0000, '0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tbhr_req_if req_ch ();
    tbhr_rsp_if rsp_ch ();
    tbhr_cfg_if cfg_ch ();

    two_button_hold_reset_controller_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    mode_t                  mode_q  [NUM_BUTTONS] = '{MODE_IDLE, MODE_IDLE};
    logic [COUNT_WIDTH-1:0] count_q [NUM_BUTTONS] = '{'0, '0};
    logic [CFG_WIDTH-1:0]   hold_reg   = HOLD_TIME_RESET;
    logic [CFG_WIDTH-1:0]   cancel_reg = CANCEL_WINDOW_RESET;

    outcome_t     expected_outcomes [$];
    int           error_count = 0;
    int           burst_left  = 8;
    int           stall_left  = 0;
    stall_style_t stall_style = STALL_NONE;

    always #5 clk = ~clk;

    function automatic outcome_t advance_buttons(input logic [CMD_WIDTH-1:0] cmd,
                                                 input logic btn);
        outcome_t o;
        int       i;
        o = '0;
        case (cmd)
            CMD_TICK:
            begin
                for (i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (mode_q[i] == MODE_PENDING || mode_q[i] == MODE_ARMED)
                    begin
                        if (count_q[i] <= 1)
                        begin
                            if (mode_q[i] == MODE_PENDING)
                            begin
                                mode_q[i]  = MODE_ARMED;
                                count_q[i] = COUNT_WIDTH'(cancel_reg);
                            end
                            else
                            begin
                                mode_q[i]  = MODE_IDLE;
                                count_q[i] = '0;
                                if (i == 0)
                                    o.factory = 1'b1;
                                else
                                    o.commission = 1'b1;
                            end
                        end
                        else
                        begin
                            count_q[i] = count_q[i] - COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            CMD_PRESS:
            begin
                if (mode_q[btn] != MODE_PENDING && mode_q[btn] != MODE_ARMED)
                begin
                    mode_q[btn]  = MODE_PENDING;
                    count_q[btn] = COUNT_WIDTH'(hold_reg);
                end
            end
            CMD_RELEASE:
            begin
                if (mode_q[btn] == MODE_PENDING)
                begin
                    mode_q[btn]  = MODE_IDLE;
                    count_q[btn] = '0;
                    if (btn == 1'b0)
                        o.confirm = 1'b1;
                    else
                        o.reject = 1'b1;
                end
                else if (mode_q[btn] == MODE_ARMED)
                begin
                    mode_q[btn]      = MODE_IDLE;
                    count_q[btn]     = '0;
                    o.cancelled[btn] = 1'b1;
                end
            end
            default: ;
        endcase
        for (i = 0; i < NUM_BUTTONS; i++)
            o.armed[i] = (mode_q[i] == MODE_ARMED);
        return o;
    endfunction

    task automatic send_request(input logic [CMD_WIDTH-1:0] cmd, input logic btn,
                                input logic known, input outcome_t want);
        outcome_t predicted;
        int       gap;
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= cmd;
        req_ch.button <= btn;
        do @(posedge clk); while (!req_ch.ready);
        predicted = advance_buttons(cmd, btn);
        expected_outcomes.push_back(known ? want : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic wait_idle();
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_registers(input logic [CFG_WIDTH-1:0] hold,
                                   input logic [CFG_WIDTH-1:0] cancel);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_HOLD_TIME;
        cfg_ch.data  <= hold;
        do @(posedge clk); while (!cfg_ch.ready);
        hold_reg = hold;
        cfg_ch.index <= REG_CANCEL_WINDOW;
        cfg_ch.data  <= cancel;
        do @(posedge clk); while (!cfg_ch.ready);
        cancel_reg = cancel;
        cfg_ch.valid <= 1'b0;
    endtask

    // press, a run of ticks with stray events on the other button, then usually release
    task automatic run_press_sequence(inout int sent);
        logic btn;
        int   span;
        int   n;
        int   k;
        btn  = 1'($urandom_range(0, 1));
        span = (hold_reg > 8 ? 8 : int'(hold_reg)) + (cancel_reg > 8 ? 8 : int'(cancel_reg)) + 3;
        n    = $urandom_range(0, span);
        send_request(CMD_PRESS, btn, 1'b0, '0);
        sent++;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(CMD_WIDTH'($urandom_range(1, 2)), ~btn, 1'b0, '0);
            else
                send_request(CMD_TICK, 1'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
        end
        if ($urandom_range(0, 9) < 7)
        begin
            send_request(CMD_RELEASE, btn, 1'b0, '0);
            sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 2));
            stall_left  = $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_style)
            STALL_NONE:  rsp_ch.ready <= 1'b1;
            STALL_HALF:  rsp_ch.ready <= 1'($urandom_range(0, 1));
            default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.confirm_pulse, rsp_ch.reject_pulse, rsp_ch.factory_reset_fire,
                    rsp_ch.commission_reset_fire, rsp_ch.cancelled_flags,
                    rsp_ch.armed_flags};
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: %b", got);
                error_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got.confirm !== want.confirm)
                begin
                    $error("confirm_pulse: expected %0b, got %0b", want.confirm, got.confirm);
                    error_count++;
                end
                if (got.reject !== want.reject)
                begin
                    $error("reject_pulse: expected %0b, got %0b", want.reject, got.reject);
                    error_count++;
                end
                if (got.factory !== want.factory)
                begin
                    $error("factory_reset_fire: expected %0b, got %0b",
                           want.factory, got.factory);
                    error_count++;
                end
                if (got.commission !== want.commission)
                begin
                    $error("commission_reset_fire: expected %0b, got %0b",
                           want.commission, got.commission);
                    error_count++;
                end
                if (got.cancelled !== want.cancelled)
                begin
                    $error("cancelled_flags: expected %b, got %b",
                           want.cancelled, got.cancelled);
                    error_count++;
                end
                if (got.armed !== want.armed)
                begin
                    $error("armed_flags: expected %b, got %b", want.armed, got.armed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        int                   r;
        int                   p;
        int                   sent;
        int                   drain_cycles;
        logic [CFG_WIDTH-1:0] hold;
        logic [CFG_WIDTH-1:0] cancel;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_TICK;
        req_ch.button = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_HOLD_TIME;
        cfg_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(plan); r++)
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_registers(plan[r].hold, plan[r].cancel);
            end
            else
            begin
                send_request(plan[r].cmd, plan[r].btn, plan[r].known, plan[r].want);
            end
        end

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    hold   = 16'd0;
                    cancel = 16'd0;
                end
                1:
                begin
                    hold   = 16'd1;
                    cancel = 16'd65535;
                end
                2:
                begin
                    hold   = 16'd65535;
                    cancel = 16'd1;
                end
                default:
                begin
                    hold   = CFG_WIDTH'($urandom_range(0, 9));
                    cancel = CFG_WIDTH'($urandom_range(0, 9));
                end
            endcase
            wait_idle();
            write_registers(hold, cancel);
            sent = 0;
            while (sent < 240)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_request(CMD_WIDTH'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 1'b0, '0);
                    sent++;
                end
                else
                begin
                    run_press_sequence(sent);
                end
                // now and then, hold off until the controller has answered everything
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
            end
        end

        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (expected_outcomes.size() != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_outcomes.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_outcomes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

/* two_button_hold_reset_controller_top.f */
src/tbhr_pkg.sv
src/tbhr_if.sv
src/tbhr_channel.sv
src/two_button_hold_reset_controller_top.sv
src/tbhr_checker.sv
dv/tb.sv
